>>> src/olid_pkg.sv
`default_nettype none
package olid_pkg;

  localparam int OLID_POS_W   = 7;
  localparam int OLID_VALUE_W = 32;
  localparam int OLID_COUNT_W = 8;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_VAL = 2'd1,
    OP_DEL_POS = 2'd2,
    OP_READ    = 2'd3
  } olid_op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_POS   = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } olid_status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } olid_state_t;

  typedef struct packed {
    olid_op_t                 op;
    logic [OLID_POS_W-1:0]    position;
    logic [OLID_VALUE_W-1:0]  value;
  } olid_req_t;

  typedef struct packed {
    olid_status_t             status;
    logic [OLID_VALUE_W-1:0]  read_value;
    logic [OLID_COUNT_W-1:0]  count;
  } olid_rsp_t;

  // broadcast to every cell
  typedef struct packed {
    logic capture;  // register compare result
    logic ins;      // open a slot at k, cells above take lower neighbor
    logic del;      // close slot k, cells at and above take upper neighbor
  } olid_cell_ctl_t;

endpackage
`default_nettype wire

>>> src/olid_cell.sv
`default_nettype none
module olid_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 7
) (
  input  wire                          clk,
  input  olid_pkg::olid_cell_ctl_t     ctl,
  input  wire [IDX_W-1:0]              index,
  input  wire [IDX_W-1:0]              k,
  input  wire [DATA_WIDTH-1:0]         value,
  input  wire [DATA_WIDTH-1:0]         lower,
  input  wire [DATA_WIDTH-1:0]         upper,
  output logic [DATA_WIDTH-1:0]        entry,
  output logic                         match,
  output logic [DATA_WIDTH-1:0]        rd_part
);
  import olid_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= (entry == value);
    end
    if (ctl.ins) begin
      if (index > k) begin
        entry <= lower;
      end else if (index == k) begin
        entry <= value;
      end
    end else if (ctl.del) begin
      if (index >= k) begin
        entry <= upper;
      end
    end
  end

  assign rd_part = (index == k) ? entry : '0;

endmodule
`default_nettype wire

>>> src/ordered_list_insert_delete_core.sv
`default_nettype none
// Ordered list of unsigned words, one storage cell per list position.
//
// Command channel: a word on req (op, position, value) is taken at a clock
// edge with start high and busy low. Ops: insert at position, delete first
// entry equal to value, delete at position, read position.
// Result channel: done pulses for one cycle with rsp (status, read_value,
// count after the op). The receiver cannot hold results off.
//
// Timing: the accept edge latches the word and every cell registers its
// compare against value. The next cycle (busy high) picks the first match,
// checks the position and, for insert and delete, shifts all cells at once
// by one slot. done shows in the cycle after that. A new word may be taken
// at the edge that ends the done cycle, but not while busy is high, so the
// core works on one op at a time.
//
// Reset: count clears to zero, no result pending. Cell contents are not
// cleared; only positions below count are ever read.
module ordered_list_insert_delete_core #(
  parameter int CAPACITY   = 128,
  parameter int DATA_WIDTH = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  olid_pkg::olid_req_t   req,
  output logic                  done,
  output olid_pkg::olid_rsp_t   rsp
);
  import olid_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > OLID_POS_W) ? CNT_W : OLID_POS_W;

  olid_state_t           state, state_next;
  olid_req_t             req_q;
  logic [CNT_W-1:0]      count_q, count_next;
  logic                  done_next;
  olid_rsp_t             rsp_next;
  olid_cell_ctl_t        ctl;
  logic [IDX_W-1:0]      k;
  logic [DATA_WIDTH-1:0] val_bus;

  logic [DATA_WIDTH-1:0] entry_w [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_w    [CAPACITY];
  logic [CAPACITY-1:0]   match_v;

  logic                  found;
  logic [IDX_W-1:0]      first_idx;
  logic [DATA_WIDTH-1:0] rd_or;
  logic [CMP_W-1:0]      cnt_ext, pos_ext;
  logic [OLID_VALUE_W+DATA_WIDTH-1:0] val_wide, rd_wide;

  assign busy = (state == ST_EXEC);

  // value as stored: low DATA_WIDTH bits, zero-extended if wider
  assign val_wide = {{DATA_WIDTH{1'b0}}, (busy ? req_q.value : req.value)};
  assign val_bus  = val_wide[DATA_WIDTH-1:0];

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] lower_w, upper_w;
      if (gi == 0) begin : g_first
        assign lower_w = '0;
      end else begin : g_mid_lo
        assign lower_w = entry_w[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign upper_w = '0;
      end else begin : g_mid_hi
        assign upper_w = entry_w[gi+1];
      end
      olid_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .IDX_W      (IDX_W)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .index   (IDX_W'(gi)),
        .k       (k),
        .value   (val_bus),
        .lower   (lower_w),
        .upper   (upper_w),
        .entry   (entry_w[gi]),
        .match   (match_v[gi]),
        .rd_part (rd_w[gi])
      );
    end
  endgenerate

  // first live match
  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!found && match_v[i] && (CNT_W'(i) < count_q)) begin
        found     = 1'b1;
        first_idx = IDX_W'(i);
      end
    end
  end

  // one-hot read select from the cells
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_w[i];
    end
  end

  assign cnt_ext = CMP_W'(count_q);
  assign pos_ext = CMP_W'(req_q.position);
  assign rd_wide = {{OLID_VALUE_W{1'b0}}, rd_or};
  assign k       = (req_q.op == OP_DEL_VAL) ? first_idx : pos_ext[IDX_W-1:0];

  always_comb begin
    state_next          = state;
    count_next          = count_q;
    done_next           = 1'b0;
    ctl                 = '0;
    rsp_next.status     = STAT_OK;
    rsp_next.read_value = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
        unique case (req_q.op)
          OP_INSERT: begin
            if (count_q == CNT_W'(CAPACITY)) begin
              rsp_next.status = STAT_FULL;
            end else if (pos_ext > cnt_ext) begin
              rsp_next.status = STAT_BAD_POS;
            end else begin
              ctl.ins    = 1'b1;
              count_next = count_q + CNT_W'(1);
            end
          end
          OP_DEL_VAL: begin
            if (found) begin
              ctl.del    = 1'b1;
              count_next = count_q - CNT_W'(1);
            end else begin
              rsp_next.status = STAT_NOT_FOUND;
            end
          end
          OP_DEL_POS: begin
            if (pos_ext >= cnt_ext) begin
              rsp_next.status = STAT_BAD_POS;
            end else begin
              ctl.del    = 1'b1;
              count_next = count_q - CNT_W'(1);
            end
          end
          OP_READ: begin
            if (pos_ext >= cnt_ext) begin
              rsp_next.status = STAT_BAD_POS;
            end else begin
              rsp_next.read_value = rd_wide[OLID_VALUE_W-1:0];
            end
          end
          default: begin
            rsp_next.status = STAT_OK;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    rsp_next.count = OLID_COUNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count_q <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      count_q <= count_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    if (done_next) begin
      rsp <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("result without an execute cycle");

  a_single_exec: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("execute phase longer than one cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_q <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == STAT_OK && req_q.op == OP_INSERT
      |-> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not add one entry");

  a_fail_keeps: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != STAT_OK |-> count_q == $past(count_q))
    else $error("failed op changed count");
`endif

endmodule
`default_nettype wire
